// File: rtl/core/obrb_pkg.sv
// Shared types and constants for the overwrite ring byte buffer.
package obrb_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ModeW = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 7;

  // Item kinds carried on the input tuser.
  localparam logic [ModeW-1:0] MODE_WRITE = 2'd0;
  localparam logic [ModeW-1:0] MODE_READ  = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd2;

  // One read request leaving the sequencer, with the tags of its result.
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            empty;
    logic [LenW-1:0] len;
  } issue_t;

  // One finished result beat.
  typedef struct packed {
    logic             empty;
    logic             last;
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] data;
  } result_t;

endpackage

// File: rtl/core/obrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module obrb_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/obrb_ctrl.sv
// Write pointer, wrap flag and read-out sequencer of the ring byte buffer.
module obrb_ctrl #(
  parameter int unsigned SIZE = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [obrb_pkg::ModeW-1:0]        in_mode_i,
  input  logic [obrb_pkg::ByteW-1:0]        in_byte_i,
  input  logic                              issue_ok_i,
  output logic                              ram_we_o,
  output logic [$clog2(SIZE)-1:0]           ram_waddr_o,
  output logic [obrb_pkg::ByteW-1:0]        ram_wdata_o,
  output logic                              ram_re_o,
  output logic [$clog2(SIZE)-1:0]           ram_raddr_o,
  output obrb_pkg::issue_t                  issue_o
);

  localparam int unsigned AddrW = $clog2(SIZE);
  localparam int unsigned PosW  = $clog2(SIZE + 1);
  localparam logic [PosW-1:0]  SizeP   = PosW'(SIZE);
  localparam logic [AddrW-1:0] LastA   = AddrW'(SIZE - 1);

  logic [PosW-1:0]              pos_q, pos_d;
  logic                         wrapped_q, wrapped_d;
  logic                         run_q, run_d;
  logic                         empty_q, empty_d;
  logic [AddrW-1:0]             addr_q, addr_d;
  logic [PosW-1:0]              remain_q, remain_d;
  logic [obrb_pkg::LenW-1:0]    len_q, len_d;
  logic                         accept;
  logic                         pos_full;
  logic [AddrW-1:0]             pos_addr;
  logic                         issue;
  logic                         run_last;

  assign in_ready_o = !run_q;
  assign accept     = in_valid_i && !run_q;
  assign pos_full   = (pos_q >= SizeP);
  // Position taken modulo SIZE; it only ever reaches SIZE itself.
  assign pos_addr   = pos_full ? '0 : pos_q[AddrW-1:0];
  assign issue      = run_q && issue_ok_i;
  assign run_last   = (remain_q == PosW'(1));

  // Write port: a write beat lands in the store in its accept cycle.
  assign ram_we_o    = accept && (in_mode_i == obrb_pkg::MODE_WRITE);
  assign ram_waddr_o = pos_addr;
  assign ram_wdata_o = in_byte_i;

  // Read port and the tags that travel with each read.
  assign ram_re_o      = issue && !empty_q;
  assign ram_raddr_o   = addr_q;
  assign issue_o.valid = issue;
  assign issue_o.last  = run_last;
  assign issue_o.empty = empty_q;
  assign issue_o.len   = len_q;

  // Next-state logic for the pointer, the wrap flag and the run.
  always_comb begin
    pos_d     = pos_q;
    wrapped_d = wrapped_q;
    run_d     = run_q;
    empty_d   = empty_q;
    addr_d    = addr_q;
    remain_d  = remain_q;
    len_d     = len_q;
    if (accept) begin
      unique case (in_mode_i)
        obrb_pkg::MODE_WRITE: begin
          pos_d     = pos_full ? PosW'(1) : pos_q + PosW'(1);
          wrapped_d = wrapped_q || pos_full;
        end
        obrb_pkg::MODE_READ: begin
          run_d = 1'b1;
          if (wrapped_q) begin
            empty_d  = 1'b0;
            addr_d   = pos_addr;
            remain_d = SizeP;
            len_d    = obrb_pkg::LenW'(SIZE);
          end else if (pos_q == '0) begin
            empty_d  = 1'b1;
            addr_d   = '0;
            remain_d = PosW'(1);
            len_d    = '0;
          end else begin
            empty_d  = 1'b0;
            addr_d   = '0;
            remain_d = pos_q;
            len_d    = obrb_pkg::LenW'(pos_q);
          end
        end
        obrb_pkg::MODE_CLEAR: begin
          pos_d     = '0;
          wrapped_d = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (issue) begin
      remain_d = remain_q - PosW'(1);
      addr_d   = (addr_q == LastA) ? '0 : addr_q + AddrW'(1);
      if (run_last) begin
        run_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      run_q     <= 1'b0;
      empty_q   <= 1'b0;
      addr_q    <= '0;
      remain_q  <= '0;
      len_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      wrapped_q <= wrapped_d;
      run_q     <= run_d;
      empty_q   <= empty_d;
      addr_q    <= addr_d;
      remain_q  <= remain_d;
      len_q     <= len_d;
    end
  end

`ifndef SYNTHESIS
  // The write position never runs past the store size.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= SizeP)
    else $error("write position beyond store size");

  // An active run always has beats left to issue.
  a_run_remain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (remain_q != '0) && (remain_q <= SizeP))
    else $error("read run without beats left");

  // A run that issued its final beat stops in the next cycle.
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && run_last |=> !run_q)
    else $error("read run continued past its final beat");
`endif

endmodule

// File: rtl/core/obrb_outq.sv
// Two-entry result queue that decouples the read pipeline from the output.
module obrb_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  obrb_pkg::result_t  push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output obrb_pkg::result_t  head_o,
  output logic [1:0]         count_o
);

  obrb_pkg::result_t entry_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = entry_q[rptr_q];
  assign count_o = cnt_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  // The issue credit must never let a beat arrive at a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2) || pop_i)
    else $error("result queue overflow");
`endif

endmodule

// File: rtl/core/overwrite_ring_byte_buffer.sv
// Write beat: one per cycle while no read run stalls the input, no result produced.
// Read beat: results pass the read registers and the result queue, then leave
// one per cycle with the output ready; input stalls while n reads (n = 1..SIZE) issue.
// Read rate is set by the single read port of the byte store, one entry per cycle.
// Reset clears the write position, the wrap flag and the result queue;
// the byte store itself is not cleared and holds undefined data until written.
module overwrite_ring_byte_buffer #(
  parameter int unsigned SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [14:8] msg_length, [15] zero
  output logic        m_axis_tlast_o,   // is_last
  output logic        m_axis_tuser_o    // is_empty
);

  localparam int unsigned AddrW = $clog2(SIZE);

  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr;
  logic [obrb_pkg::ByteW-1:0] ram_wdata;
  logic                       ram_re;
  logic [AddrW-1:0]           ram_raddr;
  logic [obrb_pkg::ByteW-1:0] ram_rdata;
  obrb_pkg::issue_t           issue;
  obrb_pkg::issue_t           infl_q;
  obrb_pkg::result_t          push_data;
  obrb_pkg::result_t          head;
  logic                       q_valid;
  logic [1:0]                 q_count;
  logic [1:0]                 occ_after;
  logic                       pop;
  logic                       issue_ok;

  // Pointer, wrap flag and read sequencer.
  obrb_ctrl #(
    .SIZE (SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .issue_ok_i  (issue_ok),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .issue_o     (issue)
  );

  // Byte store.
  obrb_ram #(
    .DataW (obrb_pkg::ByteW),
    .Depth (SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Tags of the read in flight, aligned with the store's read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
    end else begin
      infl_q <= issue;
    end
  end

  assign push_data.empty = infl_q.empty;
  assign push_data.last  = infl_q.last;
  assign push_data.len   = infl_q.len;
  assign push_data.data  = infl_q.empty ? '0 : ram_rdata;

  // Issue a read only when the queue has room for it after this cycle's pop.
  assign pop       = q_valid && m_axis_tready_i;
  assign occ_after = q_count + {1'b0, infl_q.valid} - {1'b0, pop};
  assign issue_ok  = (occ_after < 2'd2);

  // Output queue.
  obrb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (infl_q.valid),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = {1'b0, head.len, head.data};
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tuser_o  = head.empty;

endmodule

// File: tb/tb_overwrite_ring_byte_buffer.sv
// Self-checking testbench for the overwrite ring byte buffer stream block.
`timescale 1ns / 100ps

module tb_overwrite_ring_byte_buffer;

  localparam int unsigned RING_SIZE   = 64;
  localparam int unsigned RING_AW     = $clog2(RING_SIZE);
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE      = 20;

  // Mode 3 has no meaning for the block and must be dropped silently.
  localparam logic [obrb_pkg::ModeW-1:0] MODE_IGNORED = 2'd3;

  // Receiver ready patterns.
  typedef enum int unsigned {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_style_e;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        s_axis_tvalid   = 1'b0;
  logic [7:0]  s_axis_tdata    = '0;
  logic [1:0]  s_axis_tuser    = '0;
  logic        m_axis_tready   = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Own copy of the buffer state and the readout beats still owed.
  logic [obrb_pkg::ByteW-1:0] ring_mem [RING_SIZE];
  int unsigned                ring_wpos    = 0;
  logic                       ring_wrapped = 1'b0;
  obrb_pkg::result_t          readout_q[$];

  int unsigned burst_left     = 0;
  int unsigned rx_hold_left   = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned beat_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned read_count     = 0;
  int unsigned wrap_count     = 0;

  overwrite_ring_byte_buffer #(
    .SIZE(RING_SIZE)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Random byte value.
  function automatic logic [obrb_pkg::ByteW-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 255);
    return r[obrb_pkg::ByteW-1:0];
  endfunction

  // Apply one accepted input beat to the buffer copy and queue its readout.
  function automatic void model_ring_item(input logic [obrb_pkg::ModeW-1:0] mode,
                                          input logic [obrb_pkg::ByteW-1:0] data_byte);
    int unsigned       start;
    int unsigned       k;
    logic [RING_AW-1:0] idx;
    obrb_pkg::result_t beat;
    case (mode)
      obrb_pkg::MODE_WRITE: begin
        if (ring_wpos >= RING_SIZE) begin
          ring_wpos    = 0;
          ring_wrapped = 1'b1;
          wrap_count++;
        end
        idx           = RING_AW'(ring_wpos);
        ring_mem[idx] = data_byte;
        ring_wpos++;
      end
      obrb_pkg::MODE_CLEAR: begin
        ring_wpos    = 0;
        ring_wrapped = 1'b0;
      end
      obrb_pkg::MODE_READ: begin
        read_count++;
        if (ring_wrapped) begin
          // After a wrap the oldest byte sits at the write position.
          start = ring_wpos % RING_SIZE;
          for (k = 0; k < RING_SIZE; k++) begin
            idx        = RING_AW'((start + k) % RING_SIZE);
            beat.data  = ring_mem[idx];
            beat.last  = (k == RING_SIZE - 1);
            beat.empty = 1'b0;
            beat.len   = RING_SIZE[obrb_pkg::LenW-1:0];
            readout_q.push_back(beat);
          end
        end else if (ring_wpos == 0) begin
          beat       = '0;
          beat.last  = 1'b1;
          beat.empty = 1'b1;
          readout_q.push_back(beat);
        end else begin
          for (k = 0; k < ring_wpos; k++) begin
            idx        = RING_AW'(k);
            beat.data  = ring_mem[idx];
            beat.last  = (k == ring_wpos - 1);
            beat.empty = 1'b0;
            beat.len   = ring_wpos[obrb_pkg::LenW-1:0];
            readout_q.push_back(beat);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Lower tvalid and stay quiet for the given number of cycles.
  task automatic sender_rest(input int unsigned cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Offer one beat, wait for the handshake, then maybe open a gap.
  task automatic send_item(input logic [obrb_pkg::ModeW-1:0] mode,
                           input logic [obrb_pkg::ByteW-1:0] data_byte);
    int unsigned gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data_byte;
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    model_ring_item(mode, data_byte);
    if (mode != MODE_IGNORED) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) sender_rest(gap);
    end
  endtask

  // Stop offering beats until every owed readout beat has come out.
  task automatic wait_all_results();
    sender_rest(0);
    while (readout_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_random_bytes(input int unsigned count);
    repeat (count) send_item(obrb_pkg::MODE_WRITE, rand_byte());
  endtask

  // Empty reads, ignored mode, extreme bytes, clear and single-byte reads.
  task automatic test_directed_cases();
    send_item(obrb_pkg::MODE_READ, 8'hff);
    send_item(MODE_IGNORED, 8'hff);
    send_item(obrb_pkg::MODE_READ, 8'h00);
    send_item(obrb_pkg::MODE_WRITE, 8'h00);
    send_item(obrb_pkg::MODE_WRITE, 8'hff);
    send_item(obrb_pkg::MODE_WRITE, 8'h5a);
    send_item(obrb_pkg::MODE_READ, 8'h00);
    send_item(obrb_pkg::MODE_READ, 8'ha5);
    send_item(obrb_pkg::MODE_CLEAR, 8'hff);
    send_item(obrb_pkg::MODE_READ, 8'h00);
    send_item(obrb_pkg::MODE_WRITE, 8'h81);
    send_item(obrb_pkg::MODE_READ, 8'h00);
    send_item(obrb_pkg::MODE_CLEAR, 8'h00);
    send_item(obrb_pkg::MODE_CLEAR, 8'h3c);
    send_item(MODE_IGNORED, 8'h00);
    send_item(obrb_pkg::MODE_WRITE, 8'h7e);
    send_item(obrb_pkg::MODE_READ, 8'hff);
    wait_all_results();
  endtask

  // Exactly full without wrap, first wrap, full lap after wrap, multiple laps.
  task automatic test_fill_and_wrap();
    send_item(obrb_pkg::MODE_CLEAR, rand_byte());
    write_random_bytes(RING_SIZE);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    write_random_bytes(1);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    write_random_bytes(RING_SIZE - 1);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    write_random_bytes(RING_SIZE + 7);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    send_item(obrb_pkg::MODE_CLEAR, rand_byte());
    send_item(obrb_pkg::MODE_READ, rand_byte());
    write_random_bytes(5);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    wait_all_results();
  endtask

  // Receiver holds off for a long stretch while full-length reads keep coming.
  task automatic test_output_backpressure();
    send_item(obrb_pkg::MODE_CLEAR, rand_byte());
    write_random_bytes(RING_SIZE + 3);
    rx_hold_left = 400;
    repeat (3) send_item(obrb_pkg::MODE_READ, rand_byte());
    write_random_bytes(10);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    send_item(obrb_pkg::MODE_CLEAR, rand_byte());
    write_random_bytes(4);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    wait_all_results();
  endtask

  // Sender goes quiet until the block has delivered everything, then resumes.
  task automatic test_drained_pause();
    write_random_bytes(10);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    wait_all_results();
    write_random_bytes(3);
    send_item(obrb_pkg::MODE_READ, rand_byte());
    wait_all_results();
  endtask

  // Mostly write runs closed by a read, mixed with clears, lone reads and noise.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    int unsigned run;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(obrb_pkg::MODE_CLEAR, rand_byte());
        counted++;
      end else if (pick < 12) begin
        send_item(MODE_IGNORED, rand_byte());
      end else if (pick < 20) begin
        send_item(obrb_pkg::MODE_READ, rand_byte());
        counted++;
      end else if (pick < 23) begin
        wait_all_results();
      end else begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                          : $urandom_range(1, 16);
        write_random_bytes(run);
        send_item(obrb_pkg::MODE_READ, rand_byte());
        counted += run + 1;
      end
    end
  endtask

  // Receiver ready pattern, with a long hold-off counted down on request.
  initial begin : receiver_pattern
    rx_style_e   style;
    int unsigned span;
    @(posedge rst_n);
    forever begin
      style = rx_style_e'($urandom_range(0, 3));
      span  = $urandom_range(8, 150);
      repeat (span) begin
        @(negedge clk);
        if (rx_hold_left > 0) begin
          m_axis_tready <= 1'b0;
          rx_hold_left--;
        end else begin
          case (style)
            RX_STREAM: m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  // Compare every output beat with the oldest owed readout beat.
  always @(posedge clk) begin : check_readout
    obrb_pkg::result_t seen;
    obrb_pkg::result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      seen.data  = m_axis_tdata[7:0];
      seen.len   = m_axis_tdata[14:8];
      seen.last  = m_axis_tlast;
      seen.empty = m_axis_tuser;
      beat_count++;
      if (readout_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected beat: byte %02h len %0d last %b empty %b",
                   seen.data, seen.len, seen.last, seen.empty);
        end
      end else begin
        want = readout_q.pop_front();
        if (seen.data !== want.data || seen.len !== want.len ||
            seen.last !== want.last || seen.empty !== want.empty ||
            m_axis_tdata[15] !== 1'b0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("beat %0d: expected byte %02h len %0d last %b empty %b pad 0",
                     beat_count, want.data, want.len, want.last, want.empty);
            $display("beat %0d: got      byte %02h len %0d last %b empty %b pad %b",
                     beat_count, seen.data, seen.len, seen.last, seen.empty,
                     m_axis_tdata[15]);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed",
               cycle_count, readout_q.size());
      $display("overwrite_ring_byte_buffer: mismatch");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_fill_and_wrap();
    test_output_backpressure();
    test_drained_pause();
    test_random_traffic(50);
    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    $display("ran %0d beats in (%0d reads, %0d wraps), checked %0d beats out",
             items_sent, read_count, wrap_count, beat_count);
    $display("covered empty reads, full and wrapped readouts, clears, ignored mode,");
    $display("a long output hold-off and a drained pause");
    if (mismatch_count == 0 && readout_q.size() == 0) begin
      $display("overwrite_ring_byte_buffer: match");
    end else begin
      $display("%0d mismatches, %0d beats never seen", mismatch_count,
               readout_q.size());
      $display("overwrite_ring_byte_buffer: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/obrb_pkg.sv
rtl/core/obrb_ram.sv
rtl/core/obrb_ctrl.sv
rtl/core/obrb_outq.sv
rtl/core/overwrite_ring_byte_buffer.sv
tb/tb_overwrite_ring_byte_buffer.sv
